FILE: sv/mmrs_pkg.sv
// Package for the matrix multiply block with largest row sum.
// Holds command codes, fixed field widths and the control structs.
// No dependencies.
package mmrs_pkg;

	localparam int CMD_W    = 2;
	localparam int IDX_W    = 3;
	localparam int VAL_W    = 16;
	localparam int C_BITS   = 35;
	localparam int SUM_BITS = 37;

	localparam logic [CMD_W-1:0] CMD_WR_A    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WR_B    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;
	localparam logic [CMD_W-1:0] CMD_RD_C    = 2'd3;

	localparam logic KIND_READ    = 1'b0;
	localparam logic KIND_COMPUTE = 1'b1;

	typedef struct packed {
		logic wr_a;
		logic wr_b;
		logic rd_c;
		logic clr;
		logic mac;
		logic first;
		logic last;
		logic row_start;
		logic row_end;
		logic out_rd;
		logic out_cmp;
	} dp_cmd_t;

	typedef struct packed {
		logic busy;
		logic out_free;
	} dp_stat_t;

endpackage

FILE: sv/matrix_multiply_max_row_sum_top.sv
// Top level of the integer matrix multiply block with largest row sum.
// Instantiates mmrs_ctrl and mmrs_datapath; depends on mmrs_pkg.
//
// Input channel (in_valid, in_stall): each word carries command, row, col
// and value. Commands write an element of A or B, compute C = A x B, or
// read one element of C. Writes and reads with row or col not below DIM
// leave the memories unchanged; such a read returns element 0.
// Output channel (out_valid, out_stall): a read gives one word with
// result_kind 0 and element; a compute gives one word with result_kind 1 and
// peak_row_sum, the largest row sum of C floored at zero.
// A write is stored when it is accepted. A read registers the element of
// C, then loads it into the output word once the output register frees.
// A compute issues one multiply-accumulate per cycle on a single shared
// unit and then drains the pipeline. Input is stalled while a read or
// compute is in progress; the next word is taken while an output word
// still waits. A stalled receiver holds the output word and, if a new
// result is ready, holds the block until the output register frees. Reset
// clears control state and the maximum; the matrix memories hold no defined
// value until written, and C is defined only after a compute.
module matrix_multiply_max_row_sum_top #(
	parameter int DIM       = 8,
	parameter int ELEM_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [mmrs_pkg::CMD_W-1:0]           command,
	input  logic [mmrs_pkg::IDX_W-1:0]           row,
	input  logic [mmrs_pkg::IDX_W-1:0]           col,
	input  logic signed [mmrs_pkg::VAL_W-1:0]    value,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 result_kind,
	output logic signed [mmrs_pkg::C_BITS-1:0]   element,
	output logic [mmrs_pkg::SUM_BITS-1:0]        peak_row_sum
);

	localparam int AW = $clog2(DIM*DIM);

	mmrs_pkg::dp_cmd_t  cmd;
	mmrs_pkg::dp_stat_t status;
	logic [AW-1:0] a_idx, b_idx, c_idx;

	mmrs_ctrl #(
		.DIM(DIM)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.command  (command),
		.status   (status),
		.cmd      (cmd),
		.a_idx    (a_idx),
		.b_idx    (b_idx),
		.c_idx    (c_idx)
	);

	mmrs_datapath #(
		.DIM       (DIM),
		.ELEM_BITS (ELEM_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.a_idx        (a_idx),
		.b_idx        (b_idx),
		.c_idx        (c_idx),
		.row          (row),
		.col          (col),
		.value        (value),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.result_kind  (result_kind),
		.element      (element),
		.peak_row_sum (peak_row_sum),
		.status       (status)
	);

endmodule

FILE: sv/mmrs_datapath.sv
// Datapath: A, B and C memories, multiply-accumulate pipeline, row sum,
// largest row sum and the output word register.
// Depends on mmrs_pkg.
module mmrs_datapath #(
	parameter int DIM       = 8,
	parameter int ELEM_BITS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  mmrs_pkg::dp_cmd_t                      cmd,
	input  logic [$clog2(DIM*DIM)-1:0]             a_idx,
	input  logic [$clog2(DIM*DIM)-1:0]             b_idx,
	input  logic [$clog2(DIM*DIM)-1:0]             c_idx,
	input  logic [mmrs_pkg::IDX_W-1:0]             row,
	input  logic [mmrs_pkg::IDX_W-1:0]             col,
	input  logic signed [mmrs_pkg::VAL_W-1:0]      value,
	input  logic                                   out_stall,
	output logic                                   out_valid,
	output logic                                   result_kind,
	output logic signed [mmrs_pkg::C_BITS-1:0]     element,
	output logic [mmrs_pkg::SUM_BITS-1:0]          peak_row_sum,
	output mmrs_pkg::dp_stat_t                     status
);

	localparam int AW       = $clog2(DIM*DIM);
	localparam int CELLS    = DIM * DIM;
	localparam int PW       = 2 * ELEM_BITS;
	localparam int WIDE     = (PW > mmrs_pkg::C_BITS) ? PW : mmrs_pkg::C_BITS;
	localparam int ROW_BITS = mmrs_pkg::C_BITS + $clog2(DIM);

	logic signed [ELEM_BITS-1:0] mem_a [CELLS];
	logic signed [ELEM_BITS-1:0] mem_b [CELLS];
	logic signed [mmrs_pkg::C_BITS-1:0] mem_c [CELLS];

	logic [AW-1:0] host_idx;
	logic in_range;
	logic signed [ELEM_BITS-1:0] elem;

	logic signed [mmrs_pkg::C_BITS-1:0] c_rd_q;
	logic rd_in_range_q;

	logic signed [ELEM_BITS-1:0] a_s1, b_s1;
	logic v_s1, first_s1, last_s1, rs_s1, re_s1;
	logic [AW-1:0] cidx_s1;

	logic signed [PW-1:0] prod_s2;
	logic v_s2, first_s2, last_s2, rs_s2, re_s2;
	logic [AW-1:0] cidx_s2;

	logic signed [WIDE-1:0] prod_wide;
	logic [mmrs_pkg::C_BITS-1:0] acc_q, acc_next;

	logic signed [mmrs_pkg::C_BITS-1:0] cval_s3;
	logic v_s3, rs_s3, re_s3;
	logic [AW-1:0] cidx_s3;

	logic signed [ROW_BITS-1:0] row_q, row_next;
	logic signed [ROW_BITS-1:0] tot_s4;
	logic v_s4;
	logic signed [ROW_BITS-1:0] best_q;

	logic out_valid_q;
	logic kind_q;
	logic signed [mmrs_pkg::C_BITS-1:0] element_q;
	logic [mmrs_pkg::SUM_BITS-1:0] max_q;

	assign host_idx = AW'(32'(row) * DIM + 32'(col));
	assign in_range = (32'(row) < DIM) && (32'(col) < DIM);
	assign elem     = ELEM_BITS'(value);

	always_ff @(posedge clk) begin
		if (cmd.wr_a && in_range) begin
			mem_a[host_idx] <= elem;
		end
		if (cmd.wr_b && in_range) begin
			mem_b[host_idx] <= elem;
		end
		if (cmd.mac) begin
			a_s1 <= mem_a[a_idx];
			b_s1 <= mem_b[b_idx];
		end
		if (v_s3) begin
			mem_c[cidx_s3] <= cval_s3;
		end
		if (cmd.rd_c) begin
			c_rd_q        <= mem_c[host_idx];
			rd_in_range_q <= in_range;
		end
	end

	assign prod_wide = WIDE'(prod_s2);
	assign acc_next  = (first_s2 ? '0 : acc_q) + prod_wide[mmrs_pkg::C_BITS-1:0];
	assign row_next  = (rs_s3 ? '0 : row_q) + ROW_BITS'(cval_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= cmd.mac;
			v_s2 <= v_s1;
			v_s3 <= v_s2 && last_s2;
			v_s4 <= v_s3 && re_s3;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= cmd.first;
		last_s1  <= cmd.last;
		rs_s1    <= cmd.row_start;
		re_s1    <= cmd.row_end;
		cidx_s1  <= c_idx;

		prod_s2  <= a_s1 * b_s1;
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		rs_s2    <= rs_s1;
		re_s2    <= re_s1;
		cidx_s2  <= cidx_s1;

		if (v_s2) begin
			acc_q <= acc_next;
		end
		cval_s3 <= acc_next;
		rs_s3   <= rs_s2;
		re_s3   <= re_s2;
		cidx_s3 <= cidx_s2;

		if (v_s3) begin
			row_q <= row_next;
		end
		tot_s4 <= row_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= '0;
		end else if (cmd.clr) begin
			best_q <= '0;
		end else if (v_s4 && (tot_s4 > best_q)) begin
			best_q <= tot_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_rd || cmd.out_cmp) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_rd) begin
			kind_q    <= mmrs_pkg::KIND_READ;
			element_q <= rd_in_range_q ? c_rd_q : '0;
			max_q     <= '0;
		end else if (cmd.out_cmp) begin
			kind_q    <= mmrs_pkg::KIND_COMPUTE;
			element_q <= '0;
			max_q     <= mmrs_pkg::SUM_BITS'(best_q);
		end
	end

	assign out_valid       = out_valid_q;
	assign result_kind     = kind_q;
	assign element         = element_q;
	assign peak_row_sum    = max_q;
	assign status.busy     = v_s1 || v_s2 || v_s3 || v_s4;
	assign status.out_free = !out_valid_q || !out_stall;

endmodule

FILE: sv/mmrs_ctrl.sv
// Controller: accepts input words, sequences the row, column and inner
// loops of the product and schedules output words. Depends on mmrs_pkg.
module mmrs_ctrl #(
	parameter int DIM = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [mmrs_pkg::CMD_W-1:0]        command,
	input  mmrs_pkg::dp_stat_t                status,
	output mmrs_pkg::dp_cmd_t                 cmd,
	output logic [$clog2(DIM*DIM)-1:0]        a_idx,
	output logic [$clog2(DIM*DIM)-1:0]        b_idx,
	output logic [$clog2(DIM*DIM)-1:0]        c_idx
);

	localparam int AW = $clog2(DIM*DIM);
	localparam int RW = $clog2(DIM);
	localparam logic [RW-1:0] LAST = RW'(DIM - 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_MAC   = 3'd1;
	localparam logic [2:0] S_DRAIN = 3'd2;
	localparam logic [2:0] S_DONE  = 3'd3;
	localparam logic [2:0] S_RDW   = 3'd4;

	logic [2:0] state_q, state_next;
	logic [RW-1:0] r_q, c_q, k_q;
	logic accept;
	logic k_end, c_end, r_end;

	assign accept = in_valid && !in_stall;
	assign k_end  = (k_q == LAST);
	assign c_end  = (c_q == LAST);
	assign r_end  = (r_q == LAST);

	assign a_idx = AW'(32'(r_q) * DIM + 32'(k_q));
	assign b_idx = AW'(32'(k_q) * DIM + 32'(c_q));
	assign c_idx = AW'(32'(r_q) * DIM + 32'(c_q));

	always_comb begin
		in_stall      = (state_q != S_IDLE);
		state_next    = state_q;
		cmd           = '0;
		cmd.first     = (k_q == '0);
		cmd.last      = k_end;
		cmd.row_start = (c_q == '0);
		cmd.row_end   = c_end;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (command)
						mmrs_pkg::CMD_WR_A: cmd.wr_a = 1'b1;
						mmrs_pkg::CMD_WR_B: cmd.wr_b = 1'b1;
						mmrs_pkg::CMD_COMPUTE: begin
							cmd.clr    = 1'b1;
							state_next = S_MAC;
						end
						mmrs_pkg::CMD_RD_C: begin
							cmd.rd_c   = 1'b1;
							state_next = S_RDW;
						end
						default: ;
					endcase
				end
			end
			S_MAC: begin
				cmd.mac = 1'b1;
				if (k_end && c_end && r_end) begin
					state_next = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (!status.busy) begin
					state_next = S_DONE;
				end
			end
			S_DONE: begin
				if (status.out_free) begin
					cmd.out_cmp = 1'b1;
					state_next  = S_IDLE;
				end
			end
			S_RDW: begin
				if (status.out_free) begin
					cmd.out_rd = 1'b1;
					state_next = S_IDLE;
				end
			end
			default: state_next = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			r_q     <= '0;
			c_q     <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_next;
			if (cmd.clr) begin
				r_q <= '0;
				c_q <= '0;
				k_q <= '0;
			end else if (cmd.mac) begin
				k_q <= k_end ? '0 : k_q + 1'b1;
				if (k_end) begin
					c_q <= c_end ? '0 : c_q + 1'b1;
					if (c_end) begin
						r_q <= r_end ? '0 : r_q + 1'b1;
					end
				end
			end
		end
	end

`ifndef SYNTHESIS
	ast_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_rd || cmd.out_cmp) |-> status.out_free)
		else $error("Output word loaded while the output register is occupied.");
	ast_mac_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mac |-> !(cmd.wr_a || cmd.wr_b || cmd.rd_c || cmd.clr))
		else $error("Host memory access during a multiply-accumulate step.");
	ast_done_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) |-> !status.busy)
		else $error("Compute finished with the pipeline still busy.");
	ast_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !status.busy)
		else $error("Input open while the pipeline is busy.");
	ast_drain_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MAC) && (state_next == S_DRAIN) |=> (r_q == '0) && (c_q == '0))
		else $error("Loop counters did not wrap at the end of compute.");
`endif

endmodule
